// File: sv/ascii_integer_field_parser_defines.svh
// Assertion macros for the ASCII integer field parser.
// Clocked on clk_i and disabled while rst_ni is low; compiled out when SYNTH is defined.
`ifndef ASCII_INTEGER_FIELD_PARSER_DEFINES_SVH
`define ASCII_INTEGER_FIELD_PARSER_DEFINES_SVH
`ifndef SYNTH
// General clocked property check.
`define AIFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition that must never hold.
`define AIFP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define AIFP_ASSERT(lbl, prop, msg)
`define AIFP_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: sv/aifp_pkg.sv
// Package for the ASCII integer field parser: word types, codes and character helpers.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package aifp_pkg;

  // Accumulator width and fixed result width.
  localparam int unsigned AccWidth   = 64;
  localparam int unsigned ValueWidth = 64;
  localparam int unsigned CfgDataW   = 8;
  localparam int unsigned CfgIndexW  = 2;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] CfgBaseSelect = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgLongResult = 2'd1;

  // base_select register codes.
  localparam logic [1:0] SelAuto = 2'd0;
  localparam logic [1:0] SelOct  = 2'd1;
  localparam logic [1:0] SelDec  = 2'd2;
  localparam logic [1:0] SelHex  = 2'd3;

  // Characters with a special meaning.
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChLowerX = 8'h78;
  localparam logic [7:0] ChUpperX = 8'h58;

  // Digit code returned for a character that is no digit at all.
  localparam logic [4:0] NoDigit = 5'd16;

  // Base latched for the current field.
  typedef enum logic [1:0] {
    BASE_NONE = 2'd0,
    BASE_OCT  = 2'd1,
    BASE_DEC  = 2'd2,
    BASE_HEX  = 2'd3
  } aifp_base_e;

  // Field phase, one-hot.
  typedef enum logic [3:0] {
    PH_SKIP   = 4'b0001,
    PH_START  = 4'b0010,
    PH_ZERO   = 4'b0100,
    PH_DIGITS = 4'b1000
  } aifp_phase_e;

  // Input word.
  typedef struct packed {
    logic [7:0] ch;
    logic       at_end;
  } aifp_in_t;

  // Result word.
  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic                         status;
    logic [7:0]                   end_char;
    logic                         ended_by_end;
  } aifp_out_t;

  // What one parse step produces.
  typedef struct packed {
    logic      emit;
    aifp_out_t res;
  } aifp_step_t;

  // Whitespace skipped before the sign.
  function automatic logic is_ws(input logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
  endfunction

  // Value of a hex digit character, or NoDigit.
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    logic [4:0] d;
    d = NoDigit;
    if (c inside {[8'h30:8'h39]}) begin
      d = 5'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      d = 5'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      d = 5'(c - 8'h37);
    end
    return d;
  endfunction

  // Radix of a latched base.
  function automatic logic [4:0] radix(input aifp_base_e b);
    logic [4:0] r;
    case (b)
      BASE_OCT: r = 5'd8;
      BASE_HEX: r = 5'd16;
      default:  r = 5'd10;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/aifp_in_stage.sv
// Input register of the ASCII integer field parser: holds one accepted word.
// Depends on aifp_pkg for the input word type.
`timescale 1ns / 1ps
`default_nettype none

module aifp_in_stage (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire aifp_pkg::aifp_in_t in_data_i,
  input  wire logic               advance_i,
  output logic                    held_valid_o,
  output aifp_pkg::aifp_in_t      held_data_o
);

  logic               valid_d, valid_q;
  aifp_pkg::aifp_in_t data_q;
  logic               load;

  // A new word enters when the register is empty or drains this cycle.
  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_data_o  = data_q;

endmodule

`default_nettype wire

// File: sv/aifp_parse.sv
// Field state and combinational parse step of the ASCII integer field parser.
// Depends on aifp_pkg and on the assertion macros in the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "ascii_integer_field_parser_defines.svh"

module aifp_parse (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               advance_i,
  input  wire aifp_pkg::aifp_in_t item_i,
  input  wire logic [1:0]         base_select_i,
  input  wire logic               long_result_i,
  output aifp_pkg::aifp_step_t    step_o
);

  aifp_pkg::aifp_phase_e          phase_d, phase_q;
  aifp_pkg::aifp_base_e           base_d, base_q;
  logic                           neg_d, neg_q;
  logic                           saw_d, saw_q;
  logic [aifp_pkg::AccWidth-1:0]  acc_d, acc_q;

  aifp_pkg::aifp_base_e           take_base;
  logic [aifp_pkg::AccWidth-1:0]  acc_mul;
  logic [4:0]                     digit;
  logic                           take;
  logic                           start_now;
  logic                           fin;
  logic                           ch_ws;
  logic                           ch_x;

  logic signed [aifp_pkg::AccWidth-1:0] signed_val;
  logic signed [aifp_pkg::ValueWidth-1:0] ext_val;

  assign digit = aifp_pkg::digit_value(item_i.ch);
  assign ch_ws = aifp_pkg::is_ws(item_i.ch);
  assign ch_x  = item_i.ch inside {aifp_pkg::ChLowerX, aifp_pkg::ChUpperX};

  // Next field state for the word held in the input register.
  always_comb begin
    phase_d   = phase_q;
    base_d    = base_q;
    neg_d     = neg_q;
    saw_d     = saw_q;
    acc_d     = acc_q;
    take_base = base_q;
    take      = 1'b0;
    start_now = 1'b0;
    fin       = 1'b0;
    acc_mul   = '0;

    if (item_i.at_end) begin
      fin = 1'b1;
    end else begin
      case (phase_q)
        aifp_pkg::PH_SKIP: begin
          if (!ch_ws) begin
            if (item_i.ch == aifp_pkg::ChMinus) begin
              phase_d = aifp_pkg::PH_START;
              neg_d   = 1'b1;
            end else if (item_i.ch == aifp_pkg::ChPlus) begin
              phase_d = aifp_pkg::PH_START;
            end else begin
              start_now = 1'b1;
            end
          end
        end
        aifp_pkg::PH_START: begin
          start_now = 1'b1;
        end
        aifp_pkg::PH_ZERO: begin
          if (ch_x) begin
            base_d  = aifp_pkg::BASE_HEX;
            phase_d = aifp_pkg::PH_DIGITS;
          end else begin
            take = 1'b1;
          end
        end
        aifp_pkg::PH_DIGITS: begin
          take = 1'b1;
        end
        default: begin
          phase_d = aifp_pkg::PH_SKIP;
        end
      endcase
    end

    // First character after whitespace and sign: latch the base.
    if (start_now) begin
      if ((item_i.ch == aifp_pkg::ChZero) &&
          (base_select_i inside {aifp_pkg::SelAuto, aifp_pkg::SelHex})) begin
        base_d  = (base_select_i == aifp_pkg::SelAuto) ? aifp_pkg::BASE_OCT
                                                       : aifp_pkg::BASE_HEX;
        acc_d   = '0;
        saw_d   = 1'b1;
        phase_d = aifp_pkg::PH_ZERO;
      end else begin
        take_base = (base_select_i == aifp_pkg::SelAuto) ? aifp_pkg::BASE_DEC
                                                         : aifp_pkg::aifp_base_e'(base_select_i);
        base_d    = take_base;
        take      = 1'b1;
      end
    end

    // Digit step: multiply by the radix as shift-add, then add the digit.
    case (take_base)
      aifp_pkg::BASE_OCT: acc_mul = acc_q << 3;
      aifp_pkg::BASE_HEX: acc_mul = acc_q << 4;
      default:            acc_mul = (acc_q << 3) + (acc_q << 1);
    endcase
    if (take) begin
      if (digit < aifp_pkg::radix(take_base)) begin
        acc_d   = acc_mul + aifp_pkg::AccWidth'(digit);
        saw_d   = 1'b1;
        phase_d = aifp_pkg::PH_DIGITS;
      end else begin
        fin = 1'b1;
      end
    end

    // The field ends: clear everything for the next one.
    if (fin) begin
      phase_d = aifp_pkg::PH_SKIP;
      base_d  = aifp_pkg::BASE_NONE;
      neg_d   = 1'b0;
      saw_d   = 1'b0;
      acc_d   = '0;
    end
  end

  // Result from the state as it stood before this word.
  assign signed_val = neg_q ? signed'(aifp_pkg::AccWidth'(0) - acc_q) : signed'(acc_q);
  assign ext_val    = long_result_i ? aifp_pkg::ValueWidth'(signed_val)
                                    : aifp_pkg::ValueWidth'(signed'(signed_val[31:0]));

  always_comb begin
    step_o.emit             = fin;
    step_o.res.value        = saw_q ? ext_val : '0;
    step_o.res.status       = !saw_q;
    step_o.res.end_char     = item_i.at_end ? 8'h00 : item_i.ch;
    step_o.res.ended_by_end = item_i.at_end;
  end

  // Field state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= aifp_pkg::PH_SKIP;
      base_q  <= aifp_pkg::BASE_NONE;
      neg_q   <= 1'b0;
      saw_q   <= 1'b0;
      acc_q   <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      base_q  <= base_d;
      neg_q   <= neg_d;
      saw_q   <= saw_d;
      acc_q   <= acc_d;
    end
  end

  // The end marker always produces a result and leaves a cleared field.
  `AIFP_ASSERT(a_end_emits, (advance_i && item_i.at_end) |-> step_o.emit, "end without result")
  `AIFP_ASSERT(a_emit_clears, (advance_i && step_o.emit) |=> !saw_q, "field not cleared")
  `AIFP_ASSERT_NEVER(a_acc_no_digit, !saw_q && (acc_q != '0), "accumulator without digit")
  `AIFP_ASSERT_NEVER(a_sign_in_skip, neg_q && (phase_q == aifp_pkg::PH_SKIP), "stray sign")
  `AIFP_ASSERT_NEVER(a_digit_in_skip, saw_q && (phase_q == aifp_pkg::PH_SKIP), "stray digit")

endmodule

`default_nettype wire

// File: sv/aifp_out_stage.sv
// Result register of the ASCII integer field parser: holds one word until taken.
// Depends on aifp_pkg for the result word type.
`timescale 1ns / 1ps
`default_nettype none

module aifp_out_stage (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire aifp_pkg::aifp_out_t  res_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output aifp_pkg::aifp_out_t       out_data_o
);

  logic                valid_d, valid_q;
  aifp_pkg::aifp_out_t data_q;

  // Loading while a word is taken in the same cycle keeps the register full.
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// File: sv/ascii_integer_field_parser.sv
// ASCII integer field parser, usage:
// One character word enters on in_valid_i/in_ready_o (ch, at_end). Leading
// whitespace is skipped, an optional sign taken, the base chosen or forced,
// and digits accumulated until a non-digit or the end marker ends the field.
// That word then yields one result word on out_valid_o/out_ready_i (value,
// status, end_char, ended_by_end); all other words yield nothing.
// Configuration is written on cfg_valid_i/cfg_ready_o with cfg_index_i and
// cfg_data_i; cfg_ready_o is always high. Write it only while the block is idle.
// An accepted word is parsed as it leaves the input register and its result
// waits in the result register until taken. Throughput: one word per cycle
// unless a word that ends a field finds the result register full. The parse
// step (shift-add of the accumulator by the radix, or the negation of the
// finished value) sits between the input register and the result register.
// Reset clears the field state, both registers' valid flags and the
// configuration (auto base, 32-bit results).
// When the receiver stalls with a result pending, words that end no field
// still flow; a word that ends a field waits in the input register, and
// in_ready_o drops once that register is full as well.
`timescale 1ns / 1ps
`default_nettype none

module ascii_integer_field_parser (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire aifp_pkg::aifp_in_t                in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output aifp_pkg::aifp_out_t                    out_data_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [aifp_pkg::CfgIndexW-1:0]    cfg_index_i,
  input  wire logic [aifp_pkg::CfgDataW-1:0]     cfg_data_i
);

  logic                 held_valid;
  aifp_pkg::aifp_in_t   held_data;
  aifp_pkg::aifp_step_t step;
  logic                 advance;
  logic [1:0]           base_sel_d, base_sel_q;
  logic                 long_d, long_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    base_sel_d = base_sel_q;
    long_d     = long_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        aifp_pkg::CfgBaseSelect: base_sel_d = cfg_data_i[1:0];
        aifp_pkg::CfgLongResult: long_d     = cfg_data_i[0];
        default:                 ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_sel_q <= aifp_pkg::SelAuto;
      long_q     <= 1'b0;
    end else begin
      base_sel_q <= base_sel_d;
      long_q     <= long_d;
    end
  end

  // The held word is parsed unless its result finds the result register full.
  assign advance = held_valid && (!step.emit || !out_valid_o || out_ready_i);

  aifp_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .advance_i    (advance),
    .held_valid_o (held_valid),
    .held_data_o  (held_data)
  );

  aifp_parse u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .item_i        (held_data),
    .base_select_i (base_sel_q),
    .long_result_i (long_q),
    .step_o        (step)
  );

  aifp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && step.emit),
    .res_i       (step.res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
